@@ sv/pzt_pkg.sv @@
// ----------------------------------------------------------------------------
// pzt_pkg
// Shared sizes and types of the zigzag polygon triangulator.
// ----------------------------------------------------------------------------
package pzt_pkg;

    // corner buffer capacity and stored vertex width
    localparam int MAX_CORNERS = 32;
    localparam int VERTEX_BITS = 32;

    // port widths of the vertex fields
    localparam int IN_BITS  = 32;
    localparam int OUT_BITS = 32;

    // stored width: vertex bits, never more than the result field carries
    localparam int STORE_BITS = (VERTEX_BITS < OUT_BITS) ? VERTEX_BITS : OUT_BITS;

    // buffer address and corner count widths
    localparam int IDX_BITS = (MAX_CORNERS > 1) ? $clog2(MAX_CORNERS) : 1;
    localparam int CNT_BITS = $clog2(MAX_CORNERS + 1);

    // smallest polygon that yields a triangle
    localparam int MIN_CORNERS = 3;

    // polygon handed from the loader to the emitter
    typedef struct packed {
        logic                start;
        logic [CNT_BITS-1:0] n;
        logic                ovf;
    } poly_job_t;

endpackage

@@ sv/pzt_ram.sv @@
// ----------------------------------------------------------------------------
// pzt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pzt_ram #(
    parameter int   WIDTH     = 32,
    parameter int   DEPTH     = 32,
    localparam int  ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/pzt_collect.sv @@
// ----------------------------------------------------------------------------
// pzt_collect
// Corner loader: writes incoming corners into the buffer and hands the
// finished polygon to the emitter.
// ----------------------------------------------------------------------------
module pzt_collect (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [pzt_pkg::IN_BITS-1:0]    corner_vertex,
    input  logic                           last_corner,
    input  logic                           busy,
    output logic                           wr_en,
    output logic [pzt_pkg::IDX_BITS-1:0]   wr_addr,
    output logic [pzt_pkg::STORE_BITS-1:0] wr_data,
    output pzt_pkg::poly_job_t             job
);
    import pzt_pkg::*;

    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                accept;
    logic                full;
    logic [CNT_BITS-1:0] n_after;

    // corners wait while the emitter reads the buffer
    assign in_stall = busy;
    assign accept   = in_valid && !busy;
    assign full     = (count_reg >= CNT_BITS'(MAX_CORNERS));

    // buffer write, corners beyond capacity are dropped
    assign wr_en   = accept && !full;
    assign wr_addr = count_reg[IDX_BITS-1:0];
    assign wr_data = corner_vertex[STORE_BITS-1:0];

    assign n_after = count_reg + CNT_BITS'(wr_en);

    // polygon hand-over on the last corner
    always_comb
    begin
        job.start = accept && last_corner && (n_after >= CNT_BITS'(MIN_CORNERS));
        job.n     = n_after;
        job.ovf   = ovf_reg || (accept && full);
    end

    // count and overflow, cleared at polygon end
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last_corner)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                count_next = n_after;
                ovf_next   = job.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

@@ sv/pzt_emit.sv @@
// ----------------------------------------------------------------------------
// pzt_emit
// Triangle emitter: reads the corner buffer in zigzag order, one read per
// triangle after two priming reads, and drives the output register.
// ----------------------------------------------------------------------------
module pzt_emit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pzt_pkg::poly_job_t             job,
    output logic                           busy,
    output logic                           rd_en,
    output logic [pzt_pkg::IDX_BITS-1:0]   rd_addr,
    input  logic [pzt_pkg::STORE_BITS-1:0] rd_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pzt_pkg::OUT_BITS-1:0]   tri_vertex_a,
    output logic [pzt_pkg::OUT_BITS-1:0]   tri_vertex_b,
    output logic [pzt_pkg::OUT_BITS-1:0]   tri_vertex_c,
    output logic                           last_triangle,
    output logic                           corner_overflow
);
    import pzt_pkg::*;

    typedef enum logic [1:0] {E_IDLE, E_READ, E_CAPT} state_t;

    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CNT_BITS-1:0]   k_reg, k_next;
    logic [CNT_BITS-1:0]   n_reg, n_next;
    logic                  ovf_reg, ovf_next;
    logic [IDX_BITS-1:0]   lo_addr_reg, lo_addr_next;
    logic [IDX_BITS-1:0]   hi_addr_reg, hi_addr_next;
    logic [STORE_BITS-1:0] lo_cur_reg, lo_cur_next;
    logic [STORE_BITS-1:0] hi_cur_reg, hi_cur_next;
    logic [OUT_BITS-1:0]   a_reg, a_next;
    logic [OUT_BITS-1:0]   b_reg, b_next;
    logic [OUT_BITS-1:0]   c_reg, c_next;
    logic                  last_reg, last_next;
    logic                  oflag_reg, oflag_next;
    logic                  out_free;
    logic                  even;
    logic                  primed;
    logic                  final_read;

    assign busy     = (state_reg != E_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    // even reads walk up from the first corner, odd reads down from the last
    assign even       = !k_reg[0];
    // window holds two corners once reads 0 and 1 are in
    assign primed     = (k_reg > CNT_BITS'(1));
    assign final_read = (k_reg == n_reg - CNT_BITS'(1));
    assign rd_addr    = even ? lo_addr_reg : hi_addr_reg;

    // sequencer and triangle assembly
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        ovf_next       = ovf_reg;
        lo_addr_next   = lo_addr_reg;
        hi_addr_next   = hi_addr_reg;
        lo_cur_next    = lo_cur_reg;
        hi_cur_next    = hi_cur_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        last_next      = last_reg;
        oflag_next     = oflag_reg;
        rd_en          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            E_IDLE:
            begin
                if (job.start)
                begin
                    n_next       = job.n;
                    ovf_next     = job.ovf;
                    k_next       = '0;
                    lo_addr_next = '0;
                    hi_addr_next = IDX_BITS'(job.n - CNT_BITS'(1));
                    state_next   = E_READ;
                end
            end
            E_READ:
            begin
                rd_en = 1'b1;
                if (even)
                begin
                    lo_addr_next = lo_addr_reg + IDX_BITS'(1);
                end
                else
                begin
                    hi_addr_next = hi_addr_reg - IDX_BITS'(1);
                end
                state_next = E_CAPT;
            end
            E_CAPT:
            begin
                if (!primed || out_free)
                begin
                    if (even)
                    begin
                        lo_cur_next = rd_data;
                    end
                    else
                    begin
                        hi_cur_next = rd_data;
                    end
                    if (primed)
                    begin
                        out_valid_next = 1'b1;
                        if (even)
                        begin
                            a_next = OUT_BITS'(rd_data);
                            b_next = OUT_BITS'(lo_cur_reg);
                        end
                        else
                        begin
                            a_next = OUT_BITS'(lo_cur_reg);
                            b_next = OUT_BITS'(rd_data);
                        end
                        c_next     = OUT_BITS'(hi_cur_reg);
                        last_next  = final_read;
                        oflag_next = ovf_reg;
                    end
                    if (primed && final_read)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_BITS'(1);
                        state_next = E_READ;
                    end
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    // state, sequencer payload and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            n_reg         <= '0;
            ovf_reg       <= 1'b0;
            lo_addr_reg   <= '0;
            hi_addr_reg   <= '0;
            lo_cur_reg    <= '0;
            hi_cur_reg    <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            last_reg      <= 1'b0;
            oflag_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            n_reg         <= n_next;
            ovf_reg       <= ovf_next;
            lo_addr_reg   <= lo_addr_next;
            hi_addr_reg   <= hi_addr_next;
            lo_cur_reg    <= lo_cur_next;
            hi_cur_reg    <= hi_cur_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            last_reg      <= last_next;
            oflag_reg     <= oflag_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tri_vertex_a    = a_reg;
    assign tri_vertex_b    = b_reg;
    assign tri_vertex_c    = c_reg;
    assign last_triangle   = last_reg;
    assign corner_overflow = oflag_reg;

endmodule

@@ sv/polygon_zigzag_triangulator_top.sv @@
// ----------------------------------------------------------------------------
// polygon_zigzag_triangulator_top
// Zigzag triangulator: buffers one polygon's corners, then emits its
// N-2 triangles in zigzag order.
// ----------------------------------------------------------------------------
// Usage
//   Corner channel: in_valid/in_stall with corner_vertex and last_corner.
//   One corner per cycle is taken while no polygon is being emitted.
//   Triangle channel: out_valid/out_stall with three vertex indices,
//   last_triangle and corner_overflow, from an output register.
//   After the last corner's transaction the emitter first reads two corners,
//   then builds each triangle from one further read through the single read
//   port of the corner buffer, in a read state and then a capture state.
//   While triangles are emitted, in_stall is high. A stalled receiver holds
//   the triangle in the output register and the emitter waits with it.
//   Polygons under three corners give no triangles; corners past the buffer
//   capacity are dropped and flagged with corner_overflow.
//   Reset clears the corner count, overflow mark and all valids; buffer
//   contents are left as they are.
// ----------------------------------------------------------------------------
module polygon_zigzag_triangulator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [pzt_pkg::IN_BITS-1:0]  corner_vertex,
    input  logic                         last_corner,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [pzt_pkg::OUT_BITS-1:0] tri_vertex_a,
    output logic [pzt_pkg::OUT_BITS-1:0] tri_vertex_b,
    output logic [pzt_pkg::OUT_BITS-1:0] tri_vertex_c,
    output logic                         last_triangle,
    output logic                         corner_overflow
);
    import pzt_pkg::*;

    poly_job_t             job;
    logic                  busy;
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [STORE_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    logic [STORE_BITS-1:0] rd_data;

    // corner loader
    pzt_collect u_collect (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .corner_vertex (corner_vertex),
        .last_corner   (last_corner),
        .busy          (busy),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .job           (job)
    );

    // corner buffer
    pzt_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (MAX_CORNERS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // triangle emitter
    pzt_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .job             (job),
        .busy            (busy),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tri_vertex_a    (tri_vertex_a),
        .tri_vertex_b    (tri_vertex_b),
        .tri_vertex_c    (tri_vertex_c),
        .last_triangle   (last_triangle),
        .corner_overflow (corner_overflow)
    );

`ifndef SYNTH
    // a polygon is handed over only to an idle emitter
    assert property (@(posedge clk) disable iff (!rst_n) job.start |-> !busy)
        else $error("polygon started while emitter busy");

    // buffer is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && rd_en))
        else $error("corner buffer write and read overlap");

    // emitter issues its first read in the cycle after a hand-over
    assert property (@(posedge clk) disable iff (!rst_n) job.start |=> busy && rd_en)
        else $error("emitter did not begin reading after hand-over");
`endif

endmodule
